@@ rtl/ffa_pkg.sv @@
// Shared constants and types of the first-fit heap allocator.
package ffa_pkg;

	localparam int ARENA_BYTES  = 4096;
	localparam int HEADER_BYTES = 17;
	localparam int MIN_PAYLOAD  = 24;

	localparam int ADDR_W  = $clog2(ARENA_BYTES);
	localparam int END_W   = ADDR_W + 1;
	localparam int CAP_W   = ADDR_W;
	localparam int SIZE_W  = 16;
	localparam int SPLIT_W = SIZE_W + 1;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic [CAP_W-1:0] cap;
		logic             free;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		hdr_t              wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] addr;
	} res_t;

endpackage

@@ rtl/ffa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/ffa_walk.sv @@
// Request sequencer: header clearing pass, block walk, merging, splitting and freeing.
module ffa_walk import ffa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [SIZE_W-1:0] alloc_size,
	input  logic [ADDR_W-1:0] free_addr,
	output mem_req_t          mem,
	input  logic [HDR_W-1:0]  rdata,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_HDR    = 7'b0000100,
		ST_MERGE  = 7'b0001000,
		ST_DECIDE = 7'b0010000,
		ST_SPLIT  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_q, clr_d;
	logic              mode_q, mode_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic [ADDR_W-1:0] cur_q, cur_d;
	logic [CAP_W-1:0]  cap_q, cap_d;
	logic              hfree_q, hfree_d;
	logic [ADDR_W-1:0] nxt_q, nxt_d;
	res_t              res_q, res_d;

	hdr_t              rd;
	logic [END_W-1:0]  end_cur;
	logic [END_W-1:0]  end_rd;
	logic [END_W-1:0]  end_nxt;
	logic [END_W-1:0]  merged;
	logic              hfree_rd;

	assign rd       = rdata;
	assign end_cur  = END_W'(cur_q) + END_W'(HEADER_BYTES) + END_W'(cap_q);
	assign end_rd   = END_W'(cur_q) + END_W'(HEADER_BYTES) + END_W'(rd.cap);
	assign end_nxt  = END_W'(nxt_q) + END_W'(HEADER_BYTES) + END_W'(rd.cap);
	assign merged   = END_W'(cap_q) + END_W'(HEADER_BYTES) + END_W'(rd.cap);
	assign hfree_rd = rd.free | (mode_q == REQ_FREE);
	assign res      = res_q;

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		mode_d    = mode_q;
		size_d    = size_q;
		cur_d     = cur_q;
		cap_d     = cap_q;
		hfree_d   = hfree_q;
		nxt_d     = nxt_q;
		res_d     = res_q;
		mem       = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem.we    = 1'b1;
				mem.waddr = clr_q;
				if (clr_q == '0) begin
					mem.wdata.cap  = CAP_W'(ARENA_BYTES - HEADER_BYTES);
					mem.wdata.free = 1'b1;
				end
				clr_d = clr_q + ADDR_W'(1);
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mode_d = req_type;
					size_d = (alloc_size < SIZE_W'(MIN_PAYLOAD)) ?
						SIZE_W'(MIN_PAYLOAD) : alloc_size;
					if (req_type == REQ_ALLOC) begin
						cur_d     = '0;
						mem.re    = 1'b1;
						mem.raddr = '0;
						state_d   = ST_HDR;
					end else if (free_addr < ADDR_W'(HEADER_BYTES)) begin
						res_d   = '0;
						state_d = ST_DONE;
					end else begin
						cur_d     = free_addr - ADDR_W'(HEADER_BYTES);
						mem.re    = 1'b1;
						mem.raddr = free_addr - ADDR_W'(HEADER_BYTES);
						state_d   = ST_HDR;
					end
				end
			end
			ST_HDR: begin
				cap_d   = rd.cap;
				hfree_d = hfree_rd;
				if (rd.cap == '0) begin
					res_d   = '0;
					state_d = ST_DONE;
				end else if (hfree_rd && end_rd < END_W'(ARENA_BYTES)) begin
					mem.re    = 1'b1;
					mem.raddr = end_rd[ADDR_W-1:0];
					nxt_d     = end_rd[ADDR_W-1:0];
					state_d   = ST_MERGE;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_MERGE: begin
				if (rd.cap != '0 && rd.free) begin
					cap_d     = merged[CAP_W-1:0];
					mem.we    = 1'b1;
					mem.waddr = nxt_q;
					if (end_nxt < END_W'(ARENA_BYTES)) begin
						mem.re    = 1'b1;
						mem.raddr = end_nxt[ADDR_W-1:0];
						nxt_d     = end_nxt[ADDR_W-1:0];
					end else begin
						state_d = ST_DECIDE;
					end
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (mode_q == REQ_FREE) begin
					mem.we         = 1'b1;
					mem.waddr      = cur_q;
					mem.wdata.cap  = cap_q;
					mem.wdata.free = 1'b1;
					res_d.ok       = 1'b1;
					res_d.addr     = '0;
					state_d        = ST_DONE;
				end else if (hfree_q && SIZE_W'(cap_q) >= size_q) begin
					mem.we     = 1'b1;
					mem.waddr  = cur_q;
					res_d.ok   = 1'b1;
					res_d.addr = cur_q + ADDR_W'(HEADER_BYTES);
					if (SPLIT_W'(size_q) + SPLIT_W'(HEADER_BYTES + MIN_PAYLOAD)
						<= SPLIT_W'(cap_q)) begin
						mem.wdata.cap = size_q[CAP_W-1:0];
						state_d       = ST_SPLIT;
					end else begin
						mem.wdata.cap = cap_q;
						state_d       = ST_DONE;
					end
				end else begin
					if (hfree_q) begin
						mem.we         = 1'b1;
						mem.waddr      = cur_q;
						mem.wdata.cap  = cap_q;
						mem.wdata.free = 1'b1;
					end
					if (end_cur < END_W'(ARENA_BYTES)) begin
						cur_d     = end_cur[ADDR_W-1:0];
						mem.re    = 1'b1;
						mem.raddr = end_cur[ADDR_W-1:0];
						state_d   = ST_HDR;
					end else begin
						res_d   = '0;
						state_d = ST_DONE;
					end
				end
			end
			ST_SPLIT: begin
				mem.we         = 1'b1;
				mem.waddr      = cur_q + ADDR_W'(HEADER_BYTES) + size_q[ADDR_W-1:0];
				mem.wdata.cap  = cap_q - size_q[CAP_W-1:0] - CAP_W'(HEADER_BYTES);
				mem.wdata.free = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q  <= mode_d;
		size_q  <= size_d;
		cur_q   <= cur_d;
		cap_q   <= cap_d;
		hfree_q <= hfree_d;
		nxt_q   <= nxt_d;
		res_q   <= res_d;
	end

endmodule

@@ rtl/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator: header memory, sequencer and result register.
//
// Requests arrive on the in channel (in_valid/in_ready) with req_type, alloc_size and
// free_addr; each request yields exactly one result transfer on the out channel
// (out_valid/out_ready) carrying success and payload_addr.
// One request is worked on at a time, and the sequencer passes through its idle state
// between requests. After acceptance an allocate walks the block chain from offset zero
// through a header memory with a registered read, reading each header and then deciding;
// for a free block that does not end at the arena end it inspects the following blocks in
// turn, merging each free one, until a block that is not free or the arena end stops the
// merge. A split adds a write of the remainder header, and a final state hands the result
// to the output register. A free request reads its header, merges the same way and writes
// it back; a free of an address with no header ends after the header read, one below the
// header size at once. After reset the header memory is cleared one entry per cycle, and
// in_ready stays low until that pass ends; the arena then holds one free block.
// The output register lets the next request be accepted while a result waits; a stalled
// receiver holds the finished result of a following request inside the sequencer until
// the output register frees up.
module first_fit_heap_allocator import ffa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [SIZE_W-1:0] alloc_size,
	input  logic [ADDR_W-1:0] free_addr,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              success,
	output logic [ADDR_W-1:0] payload_addr
);

	mem_req_t          mem;
	logic [HDR_W-1:0]  rdata;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              out_valid_q;
	logic              success_q;
	logic [ADDR_W-1:0] payload_addr_q;

	assign res_ready    = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign success      = success_q;
	assign payload_addr = payload_addr_q;

	ffa_ram #(
		.WIDTH (HDR_W),
		.DEPTH (ARENA_BYTES)
	) u_hdr_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	ffa_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.alloc_size (alloc_size),
		.free_addr  (free_addr),
		.mem        (mem),
		.rdata      (rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			success_q      <= res.ok;
			payload_addr_q <= res.addr;
		end
	end

`ifndef ASSERT_OFF
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in progress");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> out_valid)
		else $error("result transfer did not reach the output register");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> payload_addr == '0)
		else $error("failed request returned a non-zero address");

	a_addr_past_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_addr != '0 |-> payload_addr >= ADDR_W'(HEADER_BYTES))
		else $error("granted payload address overlaps its header");
`endif

endmodule

@@ tb/first_fit_heap_allocator_tb.sv @@
// Testbench of the first-fit heap allocator: directed and random requests, checked against a block-chain predictor.
module first_fit_heap_allocator_tb;
	import ffa_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 600;
	localparam int PHASE_ITEMS = 460;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              req_type;
	logic [SIZE_W-1:0] alloc_size;
	logic [ADDR_W-1:0] free_addr;
	logic              out_valid;
	logic              out_ready;
	logic              success;
	logic [ADDR_W-1:0] payload_addr;

	first_fit_heap_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.alloc_size   (alloc_size),
		.free_addr    (free_addr),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.success      (success),
		.payload_addr (payload_addr)
	);

	// Block chain as the allocator should hold it.
	logic [CAP_W-1:0] blk_cap [ARENA_BYTES];
	bit               blk_free [ARENA_BYTES];
	bit               blk_head [ARENA_BYTES];

	res_t              expected_results [$];
	logic [ADDR_W-1:0] live_addrs [$];
	logic [ADDR_W-1:0] stale_addrs [$];

	int   err_cnt;
	int   cycles;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_active;
	event hold_go;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		hold_active = 1'b0;
		forever begin
			@(hold_go);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result transfer, success", int'(success), 0);
			end else begin
				want = expected_results.pop_front();
				if (success !== want.ok)
					report_mismatch("success", int'(success), int'(want.ok));
				if (payload_addr !== want.addr)
					report_mismatch("payload_addr", int'(payload_addr), int'(want.addr));
			end
		end
	end

	function automatic void absorb_free_run(input int h);
		int n;
		while (blk_free[h]) begin
			n = h + HEADER_BYTES + blk_cap[h];
			if (n >= ARENA_BYTES || !blk_head[n] || !blk_free[n])
				break;
			blk_cap[h] = CAP_W'(int'(blk_cap[h]) + HEADER_BYTES + int'(blk_cap[n]));
			blk_head[n] = 1'b0;
			blk_free[n] = 1'b0;
			blk_cap[n] = '0;
		end
	endfunction

	function automatic res_t predict_request(input logic rt, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] fa);
		res_t r;
		int   q;
		int   h;
		int   n;
		r = '0;
		if (rt == REQ_ALLOC) begin
			q = (sz < MIN_PAYLOAD) ? MIN_PAYLOAD : int'(sz);
			h = 0;
			while (h < ARENA_BYTES && blk_head[h]) begin
				absorb_free_run(h);
				if (blk_free[h] && int'(blk_cap[h]) >= q) begin
					if (q + HEADER_BYTES + MIN_PAYLOAD <= int'(blk_cap[h])) begin
						n = h + HEADER_BYTES + q;
						blk_cap[n] = CAP_W'(int'(blk_cap[h]) - q - HEADER_BYTES);
						blk_free[n] = 1'b1;
						blk_head[n] = 1'b1;
						blk_cap[h] = CAP_W'(q);
					end
					blk_free[h] = 1'b0;
					r.ok = 1'b1;
					r.addr = ADDR_W'(h + HEADER_BYTES);
					break;
				end
				h = h + HEADER_BYTES + blk_cap[h];
			end
		end else if (int'(fa) >= HEADER_BYTES) begin
			h = int'(fa) - HEADER_BYTES;
			if (blk_head[h]) begin
				blk_free[h] = 1'b1;
				absorb_free_run(h);
				r.ok = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic send_request(input logic rt, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] fa);
		res_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		req_type   <= rt;
		alloc_size <= sz;
		free_addr  <= fa;
		do @(posedge clk); while (!in_ready);
		r = predict_request(rt, sz, fa);
		expected_results.push_back(r);
		if (rt == REQ_ALLOC && r.ok)
			live_addrs.push_back(r.addr);
	endtask

	task automatic send_alloc(input int sz);
		send_request(REQ_ALLOC, SIZE_W'(sz), ADDR_W'($urandom_range(ARENA_BYTES - 1)));
	endtask

	task automatic send_free(input int fa);
		send_request(REQ_FREE, SIZE_W'($urandom_range(65535)), ADDR_W'(fa));
	endtask

	task automatic random_item();
		int                k;
		int                pick;
		logic [ADDR_W-1:0] a;
		k = $urandom_range(99);
		if (k < 10) begin
			case ($urandom_range(2))
				0: send_free($urandom_range(ARENA_BYTES - 1));
				1: begin
					if (stale_addrs.size() > 0)
						send_free(int'(stale_addrs[$urandom_range(stale_addrs.size() - 1)]));
					else
						send_free($urandom_range(HEADER_BYTES - 1));
				end
				default: send_alloc($urandom_range(65535));
			endcase
		end else if ((k < 50 || live_addrs.size() > 40) && live_addrs.size() > 0) begin
			pick = $urandom_range(live_addrs.size() - 1);
			a = live_addrs[pick];
			live_addrs.delete(pick);
			stale_addrs.push_back(a);
			if (stale_addrs.size() > 16)
				void'(stale_addrs.pop_front());
			send_free(int'(a));
		end else begin
			k = $urandom_range(99);
			if (k < 70)
				send_alloc($urandom_range(160));
			else if (k < 90)
				send_alloc($urandom_range(1200));
			else
				send_alloc($urandom_range(4200, 1000));
		end
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (PHASE_ITEMS) random_item();
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_free(HEADER_BYTES);
		send_free(0);
		send_free(HEADER_BYTES - 1);
		send_alloc(0);
		send_alloc(MIN_PAYLOAD - 1);
		send_alloc(MIN_PAYLOAD);
		send_alloc(65535);
		send_alloc(ARENA_BYTES);
		send_free(ARENA_BYTES - 1);
		send_free(HEADER_BYTES + 1);
		send_free(58);
		send_free(58);
		send_free(HEADER_BYTES);
		send_alloc(40);
		send_free(99);
		send_free(HEADER_BYTES);
		send_alloc(ARENA_BYTES - HEADER_BYTES);
		send_alloc(0);
		send_free(HEADER_BYTES);
		send_alloc(ARENA_BYTES - 2 * HEADER_BYTES - MIN_PAYLOAD - MIN_PAYLOAD + MIN_PAYLOAD);
		send_alloc(MIN_PAYLOAD);
		send_free(ARENA_BYTES - MIN_PAYLOAD);
		send_free(HEADER_BYTES);
		send_alloc(32768);
		live_addrs.delete();
	endtask

	task automatic test_no_idle();
		run_random_phase(0, 0);
	endtask

	task automatic test_sender_idle();
		run_random_phase(77, 0);
	endtask

	task automatic test_receiver_stall();
		run_random_phase(0, 77);
	endtask

	task automatic test_both_idle();
		run_random_phase(19, 19);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		-> hold_go;
		repeat (30) random_item();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_ALLOC;
		alloc_size = '0;
		free_addr = '0;
		out_ready = 1'b0;
		err_cnt = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < ARENA_BYTES; i++) begin
			blk_cap[i] = '0;
			blk_free[i] = 1'b0;
			blk_head[i] = 1'b0;
		end
		blk_head[0] = 1'b1;
		blk_free[0] = 1'b1;
		blk_cap[0] = CAP_W'(ARENA_BYTES - HEADER_BYTES);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();

		in_valid <= 1'b0;
		recv_stall_pct = 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/ffa_walk.sv
rtl/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_tb.sv
